>>> rtl/hf_pkg.sv
// Shared types, codes and defaults for the Huffman tree build and decode block.
// No dependencies; used by hf_core and the top level.
`default_nettype none
package hf_pkg;

  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int HDR_LEN_W = 11;
  localparam int SYM_CNT_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 1'd1;

  // Header tokens
  localparam logic [7:0] TOK_ZERO = 8'h30;
  localparam logic [7:0] TOK_ONE  = 8'h31;

  // Result kinds
  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [2:0] ERR_BAD_TOKEN = 3'd2;
  localparam logic [2:0] ERR_NOT_ONE   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd6;
  localparam logic [2:0] ERR_ONE_LEAF  = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DECODE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MERGE,
    S_HEND,
    S_HERR,
    S_WALK,
    S_DEND,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/hf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/hf_core.sv
// Tree builder and bit walker: sequencer plus node store and subtree stack RAMs.
// Depends on hf_pkg and hf_ram.
`default_nettype none
module hf_core #(
  parameter int MAX_NODES   = hf_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = hf_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_accept,
  input  wire hf_pkg::in_item_t              in_item,
  output logic                               in_ready,
  input  wire logic [hf_pkg::HDR_LEN_W-1:0]  hdr_len,
  input  wire logic [hf_pkg::SYM_CNT_W-1:0]  sym_cnt,
  input  wire logic                          out_free,
  output logic                               res_push,
  output hf_pkg::out_item_t                  res_item
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int EW  = 1 + 2 * NW + 8;
  // Node entry layout: {leaf, left, right, value}
  localparam int E_LEAF = EW - 1;
  localparam int E_LEFT = 8 + NW;
  localparam int E_RGHT = 8;

  hf_pkg::state_t state, state_next;
  hf_pkg::phase_t phase, phase_next;

  logic [7:0]  byte_r;
  logic        last_r;
  logic [SCW-1:0] sc, sc_next;
  logic [NCW-1:0] nc, nc_next;
  logic [hf_pkg::HDR_LEN_W:0] hbs, hbs_next;
  logic        expect_sym, expect_sym_next;
  logic [NW-1:0] top_node, top_node_next, top_l, top_l_next, top_r, top_r_next;
  logic        top_leaf, top_leaf_next;
  logic [NW-1:0] root_l, root_l_next, root_r, root_r_next;
  logic [NW-1:0] cur_l, cur_l_next, cur_r, cur_r_next;
  logic [hf_pkg::SYM_CNT_W-1:0] emitted, emitted_next;
  logic [2:0]  bpos, bpos_next;
  logic [3:0]  nsym, nsym_next;
  hf_pkg::out_item_t pend, pend_next;
  logic        pend_valid, pend_valid_next;

  // RAM ports
  logic          nd_we, nd_re;
  logic [NW-1:0] nd_waddr, nd_raddr;
  logic [EW-1:0] nd_wdata, nd_rdata;
  logic          st_we, st_re;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [NW-1:0] st_wdata, st_rdata;

  hf_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .re(nd_re), .raddr(nd_raddr), .rdata(nd_rdata)
  );

  hf_ram #(.WIDTH(NW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  // Shared decode of the current step
  logic [hf_pkg::HDR_LEN_W-1:0] len;
  logic [hf_pkg::HDR_LEN_W:0]   hbs_inc;
  logic        hdr_skip, nc_full, sc_full, is_merge, hend_done;
  logic [2:0]  hdr_err;
  logic        rd_leaf, stall_walk, walk_end, push_ok, cnt_reached;
  logic [hf_pkg::SYM_CNT_W-1:0] emitted_inc;

  always_comb begin
    len       = (hdr_len == '0) ? hf_pkg::HDR_LEN_W'(1) : hdr_len;
    hbs_inc   = hbs + 1'b1;
    hdr_skip  = !expect_sym && (hbs_inc >= {1'b0, len});
    nc_full   = nc >= NCW'(MAX_NODES);
    sc_full   = sc >= SCW'(STACK_DEPTH);
    hdr_err   = hf_pkg::ERR_NONE;
    if (expect_sym) begin
      if (nc_full || sc_full) hdr_err = hf_pkg::ERR_OVERFLOW;
    end else if (!hdr_skip && byte_r != hf_pkg::TOK_ONE) begin
      if (byte_r != hf_pkg::TOK_ZERO) hdr_err = hf_pkg::ERR_BAD_TOKEN;
      else if (sc < SCW'(2))          hdr_err = hf_pkg::ERR_UNDERFLOW;
      else if (nc_full)               hdr_err = hf_pkg::ERR_OVERFLOW;
    end
    is_merge    = !expect_sym && !hdr_skip && byte_r == hf_pkg::TOK_ZERO &&
                  hdr_err == hf_pkg::ERR_NONE;
    hend_done   = (hbs >= {1'b0, len}) && !expect_sym;
    push_ok     = !pend_valid || out_free;
    rd_leaf     = nd_rdata[E_LEAF];
    stall_walk  = rd_leaf && !push_ok;
    emitted_inc = rd_leaf ? emitted + 1'b1 : emitted;
    walk_end    = (bpos == 3'd0) || (emitted_inc >= sym_cnt);
    cnt_reached = emitted >= sym_cnt;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hf_pkg::S_IDLE:  if (in_accept) state_next = hf_pkg::S_EXEC;
      hf_pkg::S_EXEC: begin
        case (phase)
          hf_pkg::PH_ERROR:  state_next = hf_pkg::S_IDLE;
          hf_pkg::PH_DONE:   state_next = hf_pkg::S_FLUSH;
          hf_pkg::PH_HEADER: begin
            if (hdr_err != hf_pkg::ERR_NONE) state_next = hf_pkg::S_FLUSH;
            else if (is_merge)               state_next = hf_pkg::S_MERGE;
            else                             state_next = hf_pkg::S_HEND;
          end
          default: state_next = cnt_reached ? hf_pkg::S_FLUSH : hf_pkg::S_WALK;
        endcase
      end
      hf_pkg::S_MERGE: state_next = hf_pkg::S_HEND;
      hf_pkg::S_HEND: begin
        if (hend_done) begin
          if (sc != SCW'(1) || top_leaf)    state_next = hf_pkg::S_FLUSH;
          else if (last_r && sym_cnt != '0) state_next = hf_pkg::S_HERR;
          else                              state_next = hf_pkg::S_FLUSH;
        end else if (last_r) begin
          state_next = hf_pkg::S_FLUSH;
        end else begin
          state_next = hf_pkg::S_IDLE;
        end
      end
      hf_pkg::S_HERR: if (out_free) state_next = hf_pkg::S_FLUSH;
      hf_pkg::S_WALK: if (!stall_walk && walk_end) state_next = hf_pkg::S_DEND;
      hf_pkg::S_DEND: begin
        if (!cnt_reached && last_r) begin
          if (nsym == 4'd8 || push_ok) state_next = hf_pkg::S_FLUSH;
        end else begin
          state_next = pend_valid ? hf_pkg::S_FLUSH : hf_pkg::S_IDLE;
        end
      end
      hf_pkg::S_FLUSH: if (out_free) state_next = hf_pkg::S_IDLE;
      default: state_next = hf_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result push
  always_comb begin
    logic [NW-1:0] nl, nr;
    hf_pkg::out_item_t err_item;
    phase_next      = phase;
    sc_next         = sc;
    nc_next         = nc;
    hbs_next        = hbs;
    expect_sym_next = expect_sym;
    top_node_next   = top_node;
    top_leaf_next   = top_leaf;
    top_l_next      = top_l;
    top_r_next      = top_r;
    root_l_next     = root_l;
    root_r_next     = root_r;
    cur_l_next      = cur_l;
    cur_r_next      = cur_r;
    emitted_next    = emitted;
    bpos_next       = bpos;
    nsym_next       = nsym;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    res_push        = 1'b0;
    res_item        = pend;
    nd_we = 1'b0; nd_waddr = nc[NW-1:0]; nd_wdata = '0;
    nd_re = 1'b0; nd_raddr = cur_l;
    st_we = 1'b0; st_waddr = sc[SW-1:0]; st_wdata = nc[NW-1:0];
    st_re = 1'b0; st_raddr = SW'(sc - SCW'(2));
    nl = cur_l;
    nr = cur_r;
    err_item = '{symbol: 8'd0, kind: hf_pkg::KIND_ERROR,
                 error_code: hf_pkg::ERR_NONE, last: 1'b0};
    in_ready = (state == hf_pkg::S_IDLE);

    case (state)
      hf_pkg::S_EXEC: begin
        case (phase)
          hf_pkg::PH_ERROR: ;
          hf_pkg::PH_DONE: begin
            err_item.error_code = hf_pkg::ERR_TRAILING;
            pend_next = err_item; pend_valid_next = 1'b1;
            phase_next = hf_pkg::PH_ERROR;
          end
          hf_pkg::PH_HEADER: begin
            hbs_next = hbs_inc;
            if (hdr_err != hf_pkg::ERR_NONE) begin
              err_item.error_code = hdr_err;
              pend_next = err_item; pend_valid_next = 1'b1;
              phase_next = hf_pkg::PH_ERROR;
            end else if (expect_sym) begin
              // Push a leaf
              expect_sym_next = 1'b0;
              nd_we    = 1'b1;
              nd_wdata = {1'b1, {NW{1'b0}}, {NW{1'b0}}, byte_r};
              st_we    = 1'b1;
              sc_next  = sc + 1'b1;
              nc_next  = nc + 1'b1;
              top_node_next = nc[NW-1:0];
              top_leaf_next = 1'b1;
              top_l_next    = '0;
              top_r_next    = '0;
            end else if (is_merge) begin
              st_re = 1'b1;
            end else if (!hdr_skip) begin
              expect_sym_next = 1'b1;
            end
          end
          default: begin
            if (cnt_reached) begin
              err_item.error_code = hf_pkg::ERR_TRAILING;
              pend_next = err_item; pend_valid_next = 1'b1;
              phase_next = hf_pkg::PH_ERROR;
            end else begin
              nd_re     = 1'b1;
              nd_raddr  = byte_r[7] ? cur_r : cur_l;
              bpos_next = 3'd7;
              nsym_next = '0;
            end
          end
        endcase
      end
      hf_pkg::S_MERGE: begin
        // Parent of left (second from top) and right (top)
        nd_we    = 1'b1;
        nd_wdata = {1'b0, st_rdata, top_node, 8'd0};
        st_we    = 1'b1;
        st_waddr = SW'(sc - SCW'(2));
        sc_next  = sc - 1'b1;
        nc_next  = nc + 1'b1;
        top_node_next = nc[NW-1:0];
        top_leaf_next = 1'b0;
        top_l_next    = st_rdata;
        top_r_next    = top_node;
      end
      hf_pkg::S_HEND: begin
        if (hend_done) begin
          if (sc != SCW'(1)) begin
            err_item.error_code = hf_pkg::ERR_NOT_ONE;
            pend_next = err_item; pend_valid_next = 1'b1;
            phase_next = hf_pkg::PH_ERROR;
          end else if (top_leaf) begin
            err_item.error_code = hf_pkg::ERR_ONE_LEAF;
            pend_next = err_item; pend_valid_next = 1'b1;
            phase_next = hf_pkg::PH_ERROR;
          end else begin
            root_l_next  = top_l;
            root_r_next  = top_r;
            cur_l_next   = top_l;
            cur_r_next   = top_r;
            emitted_next = '0;
            phase_next   = (last_r && sym_cnt == '0) ? hf_pkg::PH_DONE : hf_pkg::PH_DECODE;
            pend_next = '{symbol: 8'd0, kind: hf_pkg::KIND_HEADER,
                          error_code: hf_pkg::ERR_NONE, last: 1'b0};
            pend_valid_next = 1'b1;
          end
        end else if (last_r) begin
          err_item.error_code = hf_pkg::ERR_TRUNCATED;
          pend_next = err_item; pend_valid_next = 1'b1;
          phase_next = hf_pkg::PH_ERROR;
        end
      end
      hf_pkg::S_HERR: begin
        if (out_free) begin
          res_push = 1'b1;
          err_item.error_code = hf_pkg::ERR_TRUNCATED;
          pend_next = err_item;
          phase_next = hf_pkg::PH_ERROR;
        end
      end
      hf_pkg::S_WALK: begin
        if (!stall_walk) begin
          if (rd_leaf) begin
            res_push  = pend_valid;
            pend_next = '{symbol: nd_rdata[7:0], kind: hf_pkg::KIND_SYMBOL,
                          error_code: hf_pkg::ERR_NONE, last: 1'b0};
            pend_valid_next = 1'b1;
            nsym_next = nsym + 1'b1;
            nl = root_l;
            nr = root_r;
          end else begin
            nl = nd_rdata[E_LEFT +: NW];
            nr = nd_rdata[E_RGHT +: NW];
          end
          emitted_next = emitted_inc;
          cur_l_next   = nl;
          cur_r_next   = nr;
          if (!walk_end) begin
            bpos_next = bpos - 1'b1;
            nd_re     = 1'b1;
            nd_raddr  = byte_r[bpos - 3'd1] ? nr : nl;
          end
        end
      end
      hf_pkg::S_DEND: begin
        err_item.error_code = hf_pkg::ERR_TRUNCATED;
        if (cnt_reached) begin
          phase_next = hf_pkg::PH_DONE;
        end else if (last_r) begin
          if (nsym == 4'd8) begin
            // Drop the eighth symbol to make room for the error
            pend_next  = err_item;
            phase_next = hf_pkg::PH_ERROR;
          end else if (push_ok) begin
            res_push   = pend_valid;
            pend_next  = err_item;
            pend_valid_next = 1'b1;
            phase_next = hf_pkg::PH_ERROR;
          end
        end
      end
      hf_pkg::S_FLUSH: begin
        res_item.last = 1'b1;
        if (out_free) begin
          res_push        = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hf_pkg::S_IDLE;
      phase      <= hf_pkg::PH_HEADER;
      sc         <= '0;
      nc         <= '0;
      hbs        <= '0;
      expect_sym <= 1'b0;
      emitted    <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      sc         <= sc_next;
      nc         <= nc_next;
      hbs        <= hbs_next;
      expect_sym <= expect_sym_next;
      emitted    <= emitted_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_item.in_byte;
      last_r <= in_item.last_byte;
    end
    top_node <= top_node_next;
    top_leaf <= top_leaf_next;
    top_l    <= top_l_next;
    top_r    <= top_r_next;
    root_l   <= root_l_next;
    root_r   <= root_r_next;
    cur_l    <= cur_l_next;
    cur_r    <= cur_r_next;
    bpos     <= bpos_next;
    nsym     <= nsym_next;
    pend     <= pend_next;
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SCW'(STACK_DEPTH)) else $error("subtree stack count beyond depth");
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= NCW'(MAX_NODES)) else $error("node count beyond store size");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == hf_pkg::S_IDLE |-> !pend_valid) else $error("result left pending at idle");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == hf_pkg::PH_ERROR |=> phase == hf_pkg::PH_ERROR)
    else $error("left error phase without reset");
`endif

endmodule
`default_nettype wire

>>> rtl/huffman_tree_build_and_decode.sv
// Top level: configuration registers, output register and the decode core.
// Depends on hf_pkg and hf_core.
`default_nettype none
// Builds a Huffman tree from a post-order header and decodes the bytes after it.
// Input is accepted one transaction at a time. A header byte steps through EXEC and
// HEND, with MERGE between them for a merge token, before the core is ready again.
// The byte that ends the header then hands over its result in FLUSH, after HERR for
// a following truncation error. A data byte steps through EXEC, then WALK for the
// bits walked (up to eight), stalling while a symbol cannot be pushed, then DEND and
// FLUSH to hand over its last result.
// Results leave through a one-entry output register.
// Errors are sticky until rst.
module huffman_tree_build_and_decode #(
  parameter int MAX_NODES   = hf_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = hf_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire hf_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output hf_pkg::out_item_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [hf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hf_pkg::CFG_DAT_W-1:0]  cfg_data
);

  logic [hf_pkg::HDR_LEN_W-1:0] header_length;
  logic [hf_pkg::SYM_CNT_W-1:0] symbol_count;
  logic              out_free, res_push;
  hf_pkg::out_item_t res_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= hf_pkg::HDR_LEN_W'(1);
      symbol_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hf_pkg::CFG_HEADER_LENGTH: header_length <= cfg_data[hf_pkg::HDR_LEN_W-1:0];
        hf_pkg::CFG_SYMBOL_COUNT:  symbol_count  <= cfg_data[hf_pkg::SYM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_push) begin
      out_data <= res_item;
    end
  end

  hf_core #(.MAX_NODES(MAX_NODES), .STACK_DEPTH(STACK_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_valid && in_ready),
    .in_item   (in_data),
    .in_ready  (in_ready),
    .hdr_len   (header_length),
    .sym_cnt   (symbol_count),
    .out_free  (out_free),
    .res_push  (res_push),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for huffman_tree_build_and_decode: one tree header, then data decode.
// Depends on hf_pkg and the RTL top; expected results come from a tree model held here.
`timescale 1ns / 100ps

module tb;

  localparam int NODES = hf_pkg::MAX_NODES_DEF;
  localparam int DEPTH = hf_pkg::STACK_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hf_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [hf_pkg::CFG_IDX_W-1:0] cfg_index = hf_pkg::CFG_HEADER_LENGTH;
  logic [hf_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  huffman_tree_build_and_decode dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tree model state
  bit          node_is_leaf [NODES];
  int unsigned node_left [NODES];
  int unsigned node_right [NODES];
  logic [7:0]  node_sym [NODES];
  int unsigned tree_stack [DEPTH];
  int unsigned tree_depth, nodes_used, hdr_seen, root_node, walk_node, syms_out;
  bit          want_sym;
  hf_pkg::phase_t phase;
  int unsigned hdr_len_reg, sym_count_reg;

  hf_pkg::out_item_t pending_results[$];
  int          fail_count = 0;
  int          results_seen = 0;

  function automatic void add_result(ref hf_pkg::out_item_t res[$], input logic [7:0] sym,
                                     input logic [1:0] kind, input logic [2:0] code);
    hf_pkg::out_item_t r;
    if (res.size() >= 8) return;
    r = '{symbol: sym, kind: kind, error_code: code, last: 1'b0};
    res.push_back(r);
  endfunction

  function automatic void add_error(ref hf_pkg::out_item_t res[$], input logic [2:0] code);
    phase = hf_pkg::PH_ERROR;
    add_result(res, 8'd0, hf_pkg::KIND_ERROR, code);
  endfunction

  // Consume one header byte; returns an error code or ERR_NONE.
  function automatic logic [2:0] take_header_byte(logic [7:0] b, int unsigned len);
    int unsigned pos;
    pos = hdr_seen;
    hdr_seen = pos + 1;
    if (want_sym) begin
      want_sym = 1'b0;
      if (nodes_used >= NODES || tree_depth >= DEPTH) return hf_pkg::ERR_OVERFLOW;
      node_is_leaf[nodes_used] = 1'b1;
      node_left[nodes_used] = 0;
      node_right[nodes_used] = 0;
      node_sym[nodes_used] = b;
      tree_stack[tree_depth] = nodes_used;
      tree_depth++;
      nodes_used++;
      return hf_pkg::ERR_NONE;
    end
    if (pos + 1 >= len) return hf_pkg::ERR_NONE;
    if (b == hf_pkg::TOK_ONE) begin
      want_sym = 1'b1;
      return hf_pkg::ERR_NONE;
    end
    if (b != hf_pkg::TOK_ZERO) return hf_pkg::ERR_BAD_TOKEN;
    if (tree_depth < 2) return hf_pkg::ERR_UNDERFLOW;
    if (nodes_used >= NODES) return hf_pkg::ERR_OVERFLOW;
    node_is_leaf[nodes_used] = 1'b0;
    node_right[nodes_used] = tree_stack[tree_depth-1];
    node_left[nodes_used] = tree_stack[tree_depth-2];
    node_sym[nodes_used] = 8'd0;
    tree_depth -= 2;
    tree_stack[tree_depth] = nodes_used;
    tree_depth++;
    nodes_used++;
    return hf_pkg::ERR_NONE;
  endfunction

  // Work out the results one input transaction produces.
  function automatic void decode_step(hf_pkg::in_item_t it, ref hf_pkg::out_item_t res[$]);
    int unsigned len, nxt;
    logic [2:0] code;
    res = {};
    if (phase == hf_pkg::PH_ERROR) return;
    if (phase == hf_pkg::PH_DONE) begin
      add_error(res, hf_pkg::ERR_TRAILING);
    end else if (phase == hf_pkg::PH_HEADER) begin
      len = (hdr_len_reg == 0) ? 1 : hdr_len_reg;
      code = take_header_byte(it.in_byte, len);
      if (code != hf_pkg::ERR_NONE) add_error(res, code);
      else if (hdr_seen >= len && !want_sym) begin
        if (tree_depth != 1) add_error(res, hf_pkg::ERR_NOT_ONE);
        else begin
          root_node = tree_stack[0];
          if (root_node >= NODES || node_is_leaf[root_node])
            add_error(res, hf_pkg::ERR_ONE_LEAF);
          else begin
            walk_node = root_node;
            syms_out = 0;
            phase = hf_pkg::PH_DECODE;
            add_result(res, 8'd0, hf_pkg::KIND_HEADER, hf_pkg::ERR_NONE);
            if (it.last_byte) begin
              if (sym_count_reg > 0) add_error(res, hf_pkg::ERR_TRUNCATED);
              else phase = hf_pkg::PH_DONE;
            end
          end
        end
      end else if (it.last_byte) add_error(res, hf_pkg::ERR_TRUNCATED);
    end else begin
      if (syms_out >= sym_count_reg) add_error(res, hf_pkg::ERR_TRAILING);
      else begin
        for (int b = 7; b >= 0; b--) begin
          if (syms_out >= sym_count_reg) break;
          if (walk_node >= NODES) walk_node = root_node;
          nxt = it.in_byte[b] ? node_right[walk_node] : node_left[walk_node];
          walk_node = (nxt < NODES) ? nxt : root_node;
          if (node_is_leaf[walk_node]) begin
            add_result(res, node_sym[walk_node], hf_pkg::KIND_SYMBOL, hf_pkg::ERR_NONE);
            syms_out++;
            walk_node = root_node;
          end
        end
        if (syms_out >= sym_count_reg) phase = hf_pkg::PH_DONE;
        else if (it.last_byte) begin
          if (res.size() >= 8) void'(res.pop_back());
          add_error(res, hf_pkg::ERR_TRUNCATED);
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    hf_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $realtime, out_data);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.symbol !== exp_r.symbol || out_data.kind !== exp_r.kind ||
            out_data.error_code !== exp_r.error_code || out_data.last !== exp_r.last) begin
          $display("%0t: mismatch, expected %p actual %p", $realtime, exp_r, out_data);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall;
    bit quiet;
    bit held;
    quiet = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  bit tx_quiet = 1'b0;

  // Offer one transaction; predicted results, or a typed one, are queued for checking
  task automatic send_byte(logic [7:0] b, logic lb, bit typed = 1'b0,
                           hf_pkg::out_item_t typed_r = '0);
    int gap;
    hf_pkg::in_item_t it;
    hf_pkg::out_item_t res[$];
    it = '{in_byte: b, last_byte: lb};
    if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    decode_step(it, res);
    if (typed) pending_results.push_back(typed_r);
    else foreach (res[i]) pending_results.push_back(res[i]);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected result is out, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write one register, then drop the enable again before returning
  task automatic write_reg(logic [hf_pkg::CFG_IDX_W-1:0] idx,
                           logic [hf_pkg::CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hf_pkg::CFG_HEADER_LENGTH) hdr_len_reg = val[hf_pkg::HDR_LEN_W-1:0];
    else sym_count_reg = val;
    @(posedge clk);
  endtask

  typedef struct {
    logic [7:0] b;
    logic       lb;
  } stim_row_t;

  // Opening of the header: symbol extremes, merges, and a deeper left branch
  stim_row_t lead_rows [17] = '{
    '{hf_pkg::TOK_ONE, 1'b0}, '{8'h00, 1'b0}, '{hf_pkg::TOK_ONE, 1'b0}, '{8'hFF, 1'b0},
    '{hf_pkg::TOK_ZERO, 1'b0}, '{hf_pkg::TOK_ONE, 1'b0}, '{8'h80, 1'b0},
    '{hf_pkg::TOK_ONE, 1'b0}, '{8'h7F, 1'b0}, '{hf_pkg::TOK_ZERO, 1'b0},
    '{hf_pkg::TOK_ZERO, 1'b0}, '{hf_pkg::TOK_ONE, 1'b0}, '{8'h55, 1'b0},
    '{hf_pkg::TOK_ONE, 1'b0}, '{8'hAA, 1'b0}, '{hf_pkg::TOK_ZERO, 1'b0},
    '{hf_pkg::TOK_ZERO, 1'b0}
  };

  initial begin
    logic [7:0] hdr_tail[$];
    int unsigned leaves, pushed, depth_now, extra;
    tree_depth = 0; nodes_used = 0; hdr_seen = 0; root_node = 0; walk_node = 0;
    syms_out = 0; want_sym = 1'b0; phase = hf_pkg::PH_HEADER;
    hdr_len_reg = 1; sym_count_reg = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header length set large (1024) while the tree is streamed in
    write_reg(hf_pkg::CFG_HEADER_LENGTH, 1024);
    write_reg(hf_pkg::CFG_SYMBOL_COUNT, 0);
    foreach (lead_rows[i]) send_byte(lead_rows[i].b, lead_rows[i].lb);

    // Grow the single tree with random leaves, merging as we go
    leaves = $urandom_range(25, 70);
    pushed = 0;
    depth_now = 1;
    while (pushed < leaves || depth_now > 1) begin
      if (pushed < leaves && (depth_now < 2 || $urandom_range(0, 1))) begin
        hdr_tail.push_back(hf_pkg::TOK_ONE);
        hdr_tail.push_back(8'($urandom_range(0, 255)));
        depth_now++;
        pushed++;
      end else begin
        hdr_tail.push_back(hf_pkg::TOK_ZERO);
        depth_now--;
      end
    end
    foreach (hdr_tail[i]) send_byte(hdr_tail[i], 1'b0);

    // Shrink the header so the next byte is the skipped one; sender pauses here
    drain();
    write_reg(hf_pkg::CFG_HEADER_LENGTH, hdr_seen + 1);
    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1,
              '{symbol: 8'd0, kind: hf_pkg::KIND_HEADER, error_code: hf_pkg::ERR_NONE,
                last: 1'b1});

    // Decode with an unbounded symbol count
    drain();
    write_reg(hf_pkg::CFG_SYMBOL_COUNT, 32'hFFFF_FFFF);
    repeat (250) send_byte(8'($urandom_range(0, 255)), 1'b0);

    // Bound the count a few symbols ahead and finish the stream
    drain();
    extra = $urandom_range(1, 12);
    write_reg(hf_pkg::CFG_SYMBOL_COUNT, syms_out + extra);
    while (phase == hf_pkg::PH_DECODE) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1,
              '{symbol: 8'd0, kind: hf_pkg::KIND_ERROR, error_code: hf_pkg::ERR_TRAILING,
                last: 1'b1});
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("huffman_tree_build_and_decode regression: pass");
    else
      $display("huffman_tree_build_and_decode regression: fail");
    $finish;
  end

  initial begin
    #10ms;
    $display("huffman_tree_build_and_decode regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/hf_pkg.sv
rtl/hf_ram.sv
rtl/hf_core.sv
rtl/huffman_tree_build_and_decode.sv
bench/tb.sv
